/* rtl/iirdf2_pkg.sv */
// ----------------------------------------------------------------------------
// iirdf2_pkg: shared types and constants of the Direct Form II IIR filter
// Field widths, reset values, item modes and the control groups that the
// top level drives into the history cells and the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package iirdf2_pkg;

  localparam int MAX_ORDER_DEF = 16;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 24;
  localparam int HIST_W     = 32;
  localparam int IDX_W      = 5;
  localparam int ORDER_W    = 5;
  localparam int GAIN_W     = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd10;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 25'h1000000;

  typedef enum logic [1:0] {
    MODE_FILTER  = 2'd0,
    MODE_LOAD_FB = 2'd1,
    MODE_LOAD_FF = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_GAIN = 2'd1;

  typedef struct packed {
    logic rot;
    logic tail;
    logic clr;
    logic wr;
    logic fb_we;
    logic ff_we;
  } cell_ctrl_t;

  typedef struct packed {
    logic scale;
    logic seed;
    logic mul;
    logic use_w;
    logic wsat;
    logic ysat;
  } mac_ctrl_t;

endpackage

/* rtl/iirdf2_cell.sv */
// ----------------------------------------------------------------------------
// iirdf2_cell: one stage of the history ring
// Holds one history entry and the feedback and feedforward coefficients of
// its position; passes its entry to the left neighbor when the ring turns.
// ----------------------------------------------------------------------------
module iirdf2_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  iirdf2_pkg::cell_ctrl_t               ctrl,
  input  logic signed [iirdf2_pkg::HIST_W-1:0] head,
  input  logic signed [iirdf2_pkg::HIST_W-1:0] neighbor,
  input  logic signed [iirdf2_pkg::HIST_W-1:0] w_in,
  input  logic signed [iirdf2_pkg::COEF_W-1:0] coef_in,
  output logic signed [iirdf2_pkg::HIST_W-1:0] hist,
  output logic signed [iirdf2_pkg::COEF_W-1:0] fb,
  output logic signed [iirdf2_pkg::COEF_W-1:0] ff
);

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
      fb   <= '0;
      ff   <= '0;
    end else begin
      if (ctrl.clr) begin
        hist <= '0;
      end else if (ctrl.wr) begin
        hist <= w_in;
      end else if (ctrl.rot) begin
        // the last cell in use closes the ring
        hist <= ctrl.tail ? head : neighbor;
      end
      if (ctrl.fb_we) begin
        fb <= coef_in;
      end
      if (ctrl.ff_we) begin
        ff <= coef_in;
      end
    end
  end

endmodule

/* rtl/iirdf2_mac.sv */
// ----------------------------------------------------------------------------
// iirdf2_mac: gain scaling and the two multiply-accumulate paths
// Scales the sample, sums feedback and feedforward products one tap a cycle,
// then rounds and saturates the state value and the output.
// ----------------------------------------------------------------------------
module iirdf2_mac #(
  parameter int MAX_ORDER = iirdf2_pkg::MAX_ORDER_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  iirdf2_pkg::mac_ctrl_t                  ctrl,
  input  logic signed [iirdf2_pkg::SAMPLE_W-1:0] sample,
  input  logic        [iirdf2_pkg::GAIN_W-1:0]   gain,
  input  logic signed [iirdf2_pkg::COEF_W-1:0]   fb_coef,
  input  logic signed [iirdf2_pkg::COEF_W-1:0]   ff_coef,
  input  logic signed [iirdf2_pkg::HIST_W-1:0]   hist_in,
  output logic signed [iirdf2_pkg::HIST_W-1:0]   w,
  output logic signed [iirdf2_pkg::HIST_W-1:0]   y,
  output logic                                   sat
);

  localparam int PROD_W = iirdf2_pkg::COEF_W + iirdf2_pkg::HIST_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_ORDER + 2) + 1;
  localparam int SP_W   = iirdf2_pkg::SAMPLE_W + iirdf2_pkg::GAIN_W + 1;

  localparam logic signed [ACC_W-1:0] HALF   = {{(ACC_W-20){1'b0}}, 1'b1, 19'b0};
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32'sh7FFFFFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(signed'(32'h80000000));

  logic signed [SP_W-1:0]   sp;
  logic signed [SP_W:0]     sr;
  logic signed [27:0]       scaled;
  logic signed [PROD_W-1:0] prod_a;
  logic signed [PROD_W-1:0] prod_b;
  logic                     pvld;
  logic                     pa_en;
  logic signed [ACC_W-1:0]  acc_a;
  logic signed [ACC_W-1:0]  acc_b;
  logic        [32:0]       rs_a;
  logic        [32:0]       rs_b;
  logic signed [iirdf2_pkg::HIST_W-1:0] opnd_b;

  // round half up to Q8.24, clamp to 32 bits; flag in the top bit
  function automatic logic [32:0] round_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] q;
    q = (v + HALF) >>> 20;
    if (q > SAT_HI) begin
      return {1'b1, 32'h7FFFFFFF};
    end else if (q < SAT_LO) begin
      return {1'b1, 32'h80000000};
    end else begin
      return {1'b0, q[31:0]};
    end
  endfunction

  // sample * gain, half of Q.23 added, then drop 23 fraction bits
  assign sr     = {sp[SP_W-1], sp} + (SP_W+1)'(24'sd4194304);
  assign scaled = sr[SP_W:23];
  assign opnd_b = ctrl.use_w ? w : hist_in;
  assign rs_a   = round_sat(acc_a);
  assign rs_b   = round_sat(acc_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      pvld <= 1'b0;
      sat  <= 1'b0;
    end else begin
      if (ctrl.scale) begin
        sp <= sample * $signed({1'b0, gain});
      end
      if (ctrl.seed) begin
        acc_a <= ACC_W'(scaled) <<< 20;
        acc_b <= '0;
      end else if (pvld) begin
        acc_a <= acc_a + (pa_en ? ACC_W'(prod_a) : ACC_W'(0));
        acc_b <= acc_b + ACC_W'(prod_b);
      end
      pvld <= ctrl.mul;
      if (ctrl.mul) begin
        prod_a <= fb_coef * hist_in;
        prod_b <= ff_coef * opnd_b;
        pa_en  <= !ctrl.use_w;
      end
      if (ctrl.wsat) begin
        w   <= rs_a[31:0];
        sat <= rs_a[32];
      end
      if (ctrl.ysat) begin
        y   <= rs_b[31:0];
        sat <= sat | rs_b[32];
      end
    end
  end

endmodule

/* rtl/iir_direct_form_two_filter.sv */
// ----------------------------------------------------------------------------
// iir_direct_form_two_filter: Direct Form II IIR filter of configurable order
// Each input word loads a coefficient, filters a sample or clears the
// history. History entries live in a ring of cells that turns once per sample
// past a shared multiply-accumulate unit.
//
//   channel  dir  tdata / index                              tuser
//   s_*      in   [4:0] coef_index, [28:5] coef_value,       [1:0] mode
//                 [52:29] sample_in, [55:53] zero
//   m_*      out  [31:0] sample_out                          [0] saturated
//   cfg_*    in   index 0 filter_order, 1 inverse_gain       -
//
// A filter word runs from accept to the result register through scaling, one
// turn of the history ring with one tap a cycle through the shared
// multipliers, rounding of the state value, the final feedforward tap and
// rounding of the output; no new word is taken meanwhile. Load and clear words
// leave the input open. A result that is not taken holds the block at its last
// step; the next word is accepted once the result is handed over.
// Reset (rst, synchronous) zeroes history, coefficients and the pointer and
// restores filter_order 10 and inverse_gain 1.0.
// ----------------------------------------------------------------------------
module iir_direct_form_two_filter #(
  parameter int MAX_ORDER = iirdf2_pkg::MAX_ORDER_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  input  logic [iirdf2_pkg::IN_DATA_W-1:0]         s_tdata,  // coef_index, coef_value, sample_in
  input  logic [1:0]                               s_tuser,  // mode
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  output logic [iirdf2_pkg::OUT_DATA_W-1:0]        m_tdata,  // sample_out
  output logic [0:0]                               m_tuser,  // saturated
  input  logic                                     cfg_we,
  input  logic [iirdf2_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [iirdf2_pkg::GAIN_W-1:0]            cfg_wdata
);

  localparam int ORD_W = $clog2(MAX_ORDER + 1);
  localparam int PTR_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SCALE, S_SEED, S_MAC, S_DRAIN, S_WSAT, S_WMUL, S_WADD, S_YSAT, S_OUT
  } state_t;

  state_t state;

  logic [iirdf2_pkg::ORDER_W-1:0] filter_order;
  logic [iirdf2_pkg::GAIN_W-1:0]  inverse_gain;
  logic [ORD_W-1:0]               ord_q;
  logic [ORD_W-1:0]               ord_eff;
  logic [PTR_W-1:0]               ptr;
  logic [PTR_W-1:0]               ci;
  logic [ORD_W-1:0]               step;
  logic signed [iirdf2_pkg::SAMPLE_W-1:0] sample_q;
  logic signed [iirdf2_pkg::COEF_W-1:0]   ff_last;

  // input word fields
  iirdf2_pkg::mode_t                      in_mode;
  logic [iirdf2_pkg::IDX_W-1:0]           in_idx;
  logic signed [iirdf2_pkg::COEF_W-1:0]   in_coef;
  logic signed [iirdf2_pkg::SAMPLE_W-1:0] in_sample;
  logic                                   accept;

  logic signed [iirdf2_pkg::HIST_W-1:0] hist   [MAX_ORDER];
  logic signed [iirdf2_pkg::COEF_W-1:0] fb_all [MAX_ORDER];
  logic signed [iirdf2_pkg::COEF_W-1:0] ff_all [MAX_ORDER+1];

  iirdf2_pkg::mac_ctrl_t mac_ctrl;
  logic signed [iirdf2_pkg::COEF_W-1:0] ff_sel;
  logic signed [iirdf2_pkg::HIST_W-1:0] w;
  logic signed [iirdf2_pkg::HIST_W-1:0] y;
  logic                                 sat;

  assign in_mode   = iirdf2_pkg::mode_t'(s_tuser);
  assign in_idx    = s_tdata[4:0];
  assign in_coef   = s_tdata[28:5];
  assign in_sample = s_tdata[52:29];
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;

  // clamp the order register to 1..MAX_ORDER
  always_comb begin
    if (filter_order == '0) begin
      ord_eff = ORD_W'(1);
    end else if (32'(filter_order) > MAX_ORDER) begin
      ord_eff = ORD_W'(MAX_ORDER);
    end else begin
      ord_eff = ORD_W'(filter_order);
    end
  end

  // history ring: each cell takes its right neighbor, the tail wraps to cell 0
  for (genvar c = 0; c < MAX_ORDER; c++) begin : g_cell
    iirdf2_pkg::cell_ctrl_t                cc;
    logic signed [iirdf2_pkg::HIST_W-1:0] nb;

    if (c < MAX_ORDER - 1) begin : g_mid
      assign nb = hist[c+1];
    end else begin : g_end
      assign nb = hist[0];
    end

    assign cc.rot   = (state == S_MAC) && (32'(c) < 32'(ord_q));
    assign cc.tail  = (32'(c + 1) == 32'(ord_q));
    assign cc.clr   = accept && (in_mode == iirdf2_pkg::MODE_CLEAR);
    assign cc.wr    = (state == S_WMUL) && (32'(ptr) == 32'(c));
    assign cc.fb_we = accept && (in_mode == iirdf2_pkg::MODE_LOAD_FB)
                      && (32'(in_idx) == 32'(c));
    assign cc.ff_we = accept && (in_mode == iirdf2_pkg::MODE_LOAD_FF)
                      && (32'(in_idx) == 32'(c));

    iirdf2_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (cc),
      .head     (hist[0]),
      .neighbor (nb),
      .w_in     (w),
      .coef_in  (in_coef),
      .hist     (hist[c]),
      .fb       (fb_all[c]),
      .ff       (ff_all[c])
    );
  end

  assign ff_all[MAX_ORDER] = ff_last;

  // during the ring turn the coefficient follows the tap; the final tap uses ff[order]
  assign ff_sel = (state == S_WMUL) ? ff_all[ord_q] : ff_all[ORD_W'(ci)];

  always_comb begin
    mac_ctrl       = '0;
    mac_ctrl.scale = (state == S_SCALE);
    mac_ctrl.seed  = (state == S_SEED);
    mac_ctrl.mul   = (state == S_MAC) || (state == S_WMUL);
    mac_ctrl.use_w = (state == S_WMUL);
    mac_ctrl.wsat  = (state == S_WSAT);
    mac_ctrl.ysat  = (state == S_YSAT);
  end

  iirdf2_mac #(
    .MAX_ORDER (MAX_ORDER)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (mac_ctrl),
    .sample  (sample_q),
    .gain    (inverse_gain),
    .fb_coef (fb_all[ci]),
    .ff_coef (ff_sel),
    .hist_in (hist[0]),
    .w       (w),
    .y       (y),
    .sat     (sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      filter_order <= iirdf2_pkg::ORDER_RESET;
      inverse_gain <= iirdf2_pkg::GAIN_RESET;
      ptr          <= '0;
      ci           <= '0;
      step         <= '0;
      ord_q        <= ORD_W'(1);
      ff_last      <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // config writes; indexes past the list drop
      if (cfg_we) begin
        if (cfg_index == iirdf2_pkg::REG_FILTER_ORDER) begin
          filter_order <= cfg_wdata[iirdf2_pkg::ORDER_W-1:0];
        end else if (cfg_index == iirdf2_pkg::REG_INVERSE_GAIN) begin
          inverse_gain <= cfg_wdata;
        end
      end

      // drop valid once taken, unless the next result loads in this cycle
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (in_mode)
              iirdf2_pkg::MODE_FILTER: begin
                sample_q <= in_sample;
                ord_q    <= ord_eff;
                // restart the pointer if the order was lowered below it
                if (32'(ptr) >= 32'(ord_eff)) begin
                  ptr <= '0;
                end
                state <= S_SCALE;
              end
              iirdf2_pkg::MODE_LOAD_FF: begin
                if (32'(in_idx) == MAX_ORDER) begin
                  ff_last <= in_coef;
                end
              end
              iirdf2_pkg::MODE_CLEAR: begin
                ptr <= '0;
              end
              default: begin
                // feedback loads land in the cells
              end
            endcase
          end
        end
        S_SCALE: begin
          // cell 0 shows entry k at step k; it pairs with coefficient k - ptr
          ci    <= (ptr == '0) ? '0 : PTR_W'(ord_q - ORD_W'(ptr));
          step  <= '0;
          state <= S_SEED;
        end
        S_SEED: begin
          state <= S_MAC;
        end
        S_MAC: begin
          if (32'(ci) + 1 == 32'(ord_q)) begin
            ci <= '0;
          end else begin
            ci <= ci + 1'b1;
          end
          step <= step + 1'b1;
          if (32'(step) + 1 == 32'(ord_q)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_WSAT;
        end
        S_WSAT: begin
          state <= S_WMUL;
        end
        S_WMUL: begin
          // new state value replaces the oldest entry; advance the pointer
          if (32'(ptr) + 1 >= 32'(ord_q)) begin
            ptr <= '0;
          end else begin
            ptr <= ptr + 1'b1;
          end
          state <= S_WADD;
        end
        S_WADD: begin
          state <= S_YSAT;
        end
        S_YSAT: begin
          state <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= y;
            m_tuser[0] <= sat;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/iirdf2_checker.sv */
// ----------------------------------------------------------------------------
// iirdf2_checker: port-level checks of the IIR filter
// Tracks filter words in flight and checks that no result comes without one, stalls, busy and reset.
// ----------------------------------------------------------------------------
module iirdf2_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_tvalid,
  input logic                                 s_tready,
  input logic [1:0]                           s_tuser,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [iirdf2_pkg::OUT_DATA_W-1:0]    m_tdata,
  input logic [0:0]                           m_tuser
);

  logic [1:0] pending;
  logic       filt_acc;
  logic       out_acc;

  assign filt_acc = s_tvalid && s_tready && (s_tuser == iirdf2_pkg::MODE_FILTER);
  assign out_acc  = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(filt_acc) - 2'(out_acc);
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> pending != 2'd0)
    else $error("result word without a filter word");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two filter words in flight");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    filt_acc |=> !s_tready)
    else $error("filter word did not make the block busy");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind iir_direct_form_two_filter iirdf2_checker u_iirdf2_checker (.*);

/* sim/iirdf2_output_checker.sv */
// ----------------------------------------------------------------------------
// iirdf2_output_checker: predicts and checks the IIR filter output stream
// Watches the input, result and register-write channels of the filter. Keeps
// its own copy of registers, coefficients and history, works out the result
// of every accepted filter word and compares each result word in order.
// ----------------------------------------------------------------------------
module iirdf2_output_checker #(
  parameter int MAX_ORDER = iirdf2_pkg::MAX_ORDER_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  input  logic                                 s_tready,
  input  logic [iirdf2_pkg::IN_DATA_W-1:0]     s_tdata,  // coef_index, coef_value, sample_in
  input  logic [1:0]                           s_tuser,  // mode
  input  logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic [iirdf2_pkg::OUT_DATA_W-1:0]    m_tdata,  // sample_out
  input  logic [0:0]                           m_tuser,  // saturated
  input  logic                                 cfg_we,
  input  logic [iirdf2_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [iirdf2_pkg::GAIN_W-1:0]        cfg_wdata,
  output int                                   mismatch_count,
  output int                                   samples_due,
  output int                                   samples_checked,
  output int                                   samples_clipped
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_W   = iirdf2_pkg::HIST_W;
  localparam int COEF_W   = iirdf2_pkg::COEF_W;
  localparam int SAMPLE_W = iirdf2_pkg::SAMPLE_W;
  localparam int IDX_W    = iirdf2_pkg::IDX_W;
  localparam int ORDER_W  = iirdf2_pkg::ORDER_W;
  localparam int GAIN_W   = iirdf2_pkg::GAIN_W;

  localparam longint Q824_MAX = 64'sd2147483647;
  localparam longint Q824_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [HIST_W-1:0] sample_out;
    logic                     saturated;
  } filtered_word_t;

  logic [ORDER_W-1:0]       order_reg;
  logic [GAIN_W-1:0]        gain_reg;
  logic signed [HIST_W-1:0] history [MAX_ORDER];
  int unsigned              oldest;
  logic signed [COEF_W-1:0] fb_coef [MAX_ORDER];
  logic signed [COEF_W-1:0] ff_coef [MAX_ORDER+1];
  filtered_word_t           expected_samples [$];
  int                       errs;
  int                       checked;
  int                       clipped;

  // Round half up, then floor-divide by 2^sh.
  function automatic longint round_q(longint v, int unsigned sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // Returns {hit, value} with value clipped to signed Q8.24.
  function automatic logic [HIST_W:0] clamp_q824(longint v);
    if (v > Q824_MAX) return {1'b1, 32'h7FFFFFFF};
    if (v < Q824_MIN) return {1'b1, 32'h80000000};
    return {1'b0, v[HIST_W-1:0]};
  endfunction

  function automatic filtered_word_t predict_filter_sample(logic signed [SAMPLE_W-1:0] sample);
    int unsigned     taps;
    int unsigned     pos;
    int unsigned     k;
    longint          acc_w;
    longint          acc_y;
    logic [HIST_W:0] w_clamped;
    logic [HIST_W:0] y_clamped;
    filtered_word_t  res;
    taps = (order_reg == 0) ? 1 : (order_reg > MAX_ORDER) ? MAX_ORDER : order_reg;
    if (oldest >= taps) oldest = 0;
    acc_w = round_q(longint'(sample) * longint'(gain_reg), 23) <<< 20;
    acc_y = 0;
    pos = oldest;
    for (k = 0; k < taps; k++) begin
      acc_w += longint'(fb_coef[k]) * longint'(history[pos]);
      acc_y += longint'(ff_coef[k]) * longint'(history[pos]);
      pos = (pos + 1 >= taps) ? 0 : pos + 1;
    end
    w_clamped = clamp_q824(round_q(acc_w, 20));
    acc_y += longint'(ff_coef[taps]) * longint'($signed(w_clamped[HIST_W-1:0]));
    y_clamped = clamp_q824(round_q(acc_y, 20));
    history[oldest] = w_clamped[HIST_W-1:0];
    oldest = (oldest + 1 >= taps) ? 0 : oldest + 1;
    res.sample_out = y_clamped[HIST_W-1:0];
    res.saturated  = w_clamped[HIST_W] | y_clamped[HIST_W];
    return res;
  endfunction

  always @(posedge clk) begin : watch
    filtered_word_t           want;
    logic [IDX_W-1:0]         idx;
    logic signed [COEF_W-1:0] coef;
    if (rst) begin
      order_reg = iirdf2_pkg::ORDER_RESET;
      gain_reg  = iirdf2_pkg::GAIN_RESET;
      oldest    = 0;
      foreach (history[i]) history[i] = '0;
      foreach (fb_coef[i]) fb_coef[i] = '0;
      foreach (ff_coef[i]) ff_coef[i] = '0;
      expected_samples.delete();
      errs    = 0;
      checked = 0;
      clipped = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          iirdf2_pkg::REG_FILTER_ORDER: order_reg = cfg_wdata[ORDER_W-1:0];
          iirdf2_pkg::REG_INVERSE_GAIN: gain_reg  = cfg_wdata;
          default: ;
        endcase
      end
      // retire the oldest expectation before queuing a new one
      if (m_tvalid && m_tready) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected result word: sample_out %0d, saturated %0b",
                 $signed(m_tdata), m_tuser[0]);
          errs++;
        end else begin
          want = expected_samples.pop_front();
          checked++;
          if (want.saturated) clipped++;
          if (m_tdata !== want.sample_out) begin
            $error("sample_out: expected %0d, actual %0d",
                   $signed(want.sample_out), $signed(m_tdata));
            errs++;
          end
          if (m_tuser[0] !== want.saturated) begin
            $error("saturated: expected %0b, actual %0b", want.saturated, m_tuser[0]);
            errs++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        idx  = s_tdata[IDX_W-1:0];
        coef = s_tdata[IDX_W+COEF_W-1:IDX_W];
        case (iirdf2_pkg::mode_t'(s_tuser))
          iirdf2_pkg::MODE_FILTER:
            expected_samples.push_back(
              predict_filter_sample(s_tdata[IDX_W+COEF_W+SAMPLE_W-1:IDX_W+COEF_W]));
          iirdf2_pkg::MODE_LOAD_FB: if (idx < MAX_ORDER) fb_coef[idx] = coef;
          iirdf2_pkg::MODE_LOAD_FF: if (idx <= MAX_ORDER) ff_coef[idx] = coef;
          default: begin
            foreach (history[i]) history[i] = '0;
            oldest = 0;
          end
        endcase
      end
    end
    mismatch_count  <= errs;
    samples_due     <= expected_samples.size();
    samples_checked <= checked;
    samples_clipped <= clipped;
  end

endmodule

/* sim/iir_direct_form_two_filter_tb.sv */
// ----------------------------------------------------------------------------
// iir_direct_form_two_filter_tb: stimulus and verdict for the IIR filter
// Drives coefficient loads, samples and history clears through the input
// stream and register writes while idle, with random source gaps and sink
// stalls. The checker beside the filter predicts and compares every result.
// ----------------------------------------------------------------------------
module iir_direct_form_two_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_DATA_W  = iirdf2_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = iirdf2_pkg::OUT_DATA_W;
  localparam int CFG_IDX_W  = iirdf2_pkg::CFG_IDX_W;
  localparam int GAIN_W     = iirdf2_pkg::GAIN_W;
  localparam int COEF_W     = iirdf2_pkg::COEF_W;
  localparam int SAMPLE_W   = iirdf2_pkg::SAMPLE_W;
  localparam int IDX_W      = iirdf2_pkg::IDX_W;
  localparam int ORDER_W    = iirdf2_pkg::ORDER_W;

  localparam int MAX_ORDER     = iirdf2_pkg::MAX_ORDER_DEF;
  localparam int RANDOM_WORDS  = 1400;
  localparam int SETTLE_CYCLES = 32;      // longer than a filter word takes at the maximum order
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RUN_LIMIT_NS  = 5000000;

  // register indexes the filter does not decode
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

  localparam logic signed [COEF_W-1:0]   COEF_MAX   = 24'sh7FFFFF;
  localparam logic signed [COEF_W-1:0]   COEF_MIN   = 24'sh800000;
  localparam logic signed [COEF_W-1:0]   COEF_UNITY = 24'sh100000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata   = '0;   // coef_index, coef_value, sample_in
  logic [1:0]             s_tuser   = '0;   // mode
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;          // sample_out
  logic [0:0]             m_tuser;          // saturated
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [GAIN_W-1:0]      cfg_wdata = '0;

  int mismatch_count;
  int samples_due;
  int samples_checked;
  int samples_clipped;

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;

  int unsigned words_sent;
  int unsigned effective_words;
  int unsigned filter_words;
  int unsigned load_words;
  int unsigned clear_words;
  int unsigned cfg_writes;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  iir_direct_form_two_filter u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  iirdf2_output_checker #(.MAX_ORDER(MAX_ORDER)) u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .samples_due     (samples_due),
    .samples_checked (samples_checked),
    .samples_clipped (samples_clipped)
  );

  // Sink side: stall at the rate of the current phase, a fresh draw each cycle.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Full-range coefficient when span is zero, else uniform in [-span, span].
  function automatic logic signed [COEF_W-1:0] rand_coef(int unsigned span);
    if (span == 0) return COEF_W'($urandom);
    return COEF_W'(int'($urandom_range(0, 2 * span)) - int'(span));
  endfunction

  // Mostly full-scale samples, a quarter of them quiet.
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    if ($urandom_range(0, 3) == 0)
      return SAMPLE_W'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
    return SAMPLE_W'($urandom);
  endfunction

  // Present one word and hold it until the filter takes it. Idle cycles go in
  // front of the word; valid stays high across back-to-back words.
  task automatic send_word(iirdf2_pkg::mode_t mode, logic [IDX_W-1:0] idx,
                           logic signed [COEF_W-1:0] coef,
                           logic signed [SAMPLE_W-1:0] sample);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, sample, coef, idx};
    s_tuser  <= mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    case (mode)
      iirdf2_pkg::MODE_FILTER: filter_words++;
      iirdf2_pkg::MODE_CLEAR:  clear_words++;
      default:                 load_words++;
    endcase
    // loads aimed past the coefficient banks do nothing; leave them out of the count
    if (!((mode == iirdf2_pkg::MODE_LOAD_FB && idx >= MAX_ORDER) ||
          (mode == iirdf2_pkg::MODE_LOAD_FF && idx > MAX_ORDER)))
      effective_words++;
  endtask

  // Drop valid and hold off until every expected result has come back, then
  // give trailing load or clear words time to finish.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (samples_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [GAIN_W-1:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  task automatic run_directed();
    // unity on the newest feedforward tap, extreme feedback at both ring ends
    send_word(iirdf2_pkg::MODE_LOAD_FF, 5'd10, COEF_UNITY, '0);
    send_word(iirdf2_pkg::MODE_LOAD_FB, 5'd0, COEF_MIN, '0);
    send_word(iirdf2_pkg::MODE_LOAD_FB, 5'd9, COEF_MAX, '0);
    // feedback bank ends at 15: index 16 is dropped
    send_word(iirdf2_pkg::MODE_LOAD_FB, 5'd16, COEF_MAX, SAMPLE_MAX);
    // feedforward 16 is valid, used once the order reaches the maximum
    send_word(iirdf2_pkg::MODE_LOAD_FF, 5'd16, COEF_MAX, '0);
    send_word(iirdf2_pkg::MODE_LOAD_FF, 5'd31, COEF_MIN, SAMPLE_MIN);
    send_word(iirdf2_pkg::MODE_FILTER, 5'd31, COEF_MIN, SAMPLE_MAX);
    send_word(iirdf2_pkg::MODE_FILTER, '0, '0, SAMPLE_MIN);
    send_word(iirdf2_pkg::MODE_FILTER, '0, COEF_MAX, SAMPLE_MAX);
    send_word(iirdf2_pkg::MODE_FILTER, '0, '0, SAMPLE_MAX);
    send_word(iirdf2_pkg::MODE_CLEAR, 5'd31, COEF_MAX, SAMPLE_MAX);
    settle();
    // advance the pointer to 5, then shrink the order below it
    repeat (5) send_word(iirdf2_pkg::MODE_FILTER, '0, '0, SAMPLE_MAX);
    write_reg(iirdf2_pkg::REG_FILTER_ORDER, 25'd3);
    send_word(iirdf2_pkg::MODE_FILTER, '0, '0, SAMPLE_MAX);
    send_word(iirdf2_pkg::MODE_FILTER, '0, '0, SAMPLE_MIN);
    // order zero runs as a single stage, anything above the maximum as the maximum
    write_reg(iirdf2_pkg::REG_FILTER_ORDER, 25'd0);
    send_word(iirdf2_pkg::MODE_FILTER, '0, '0, SAMPLE_MAX);
    write_reg(iirdf2_pkg::REG_FILTER_ORDER, {20'hFFFFF, 5'd31});
    send_word(iirdf2_pkg::MODE_FILTER, '0, '0, SAMPLE_MIN);
    // gain extremes
    write_reg(iirdf2_pkg::REG_INVERSE_GAIN, '0);
    send_word(iirdf2_pkg::MODE_FILTER, '0, '0, SAMPLE_MAX);
    write_reg(iirdf2_pkg::REG_INVERSE_GAIN, '1);
    send_word(iirdf2_pkg::MODE_FILTER, '0, '0, SAMPLE_MIN);
    // writes to undecoded indexes must leave both registers alone
    write_reg(REG_UNUSED_A, '1);
    write_reg(REG_UNUSED_B, 25'd1);
    send_word(iirdf2_pkg::MODE_FILTER, '0, '0, SAMPLE_MAX);
    write_reg(iirdf2_pkg::REG_FILTER_ORDER, 25'(iirdf2_pkg::ORDER_RESET));
    write_reg(iirdf2_pkg::REG_INVERSE_GAIN, iirdf2_pkg::GAIN_RESET);
    send_word(iirdf2_pkg::MODE_CLEAR, '0, '0, '0);
  endtask

  // One episode: a register setting, a full coefficient set, then a sample run
  // mixed with stray loads, clears and an occasional drain.
  task automatic run_episode();
    logic [ORDER_W-1:0] order;
    logic [GAIN_W-1:0]  gain;
    logic [19:0]        junk;
    int unsigned        taps;
    int unsigned        pick;
    int unsigned        k;
    int unsigned        run_len;
    bit                 tame;
    pick = $urandom_range(0, 19);
    if (pick == 0) order = '0;
    else if (pick == 1) order = ORDER_W'($urandom_range(MAX_ORDER + 1, 31));
    else if (pick < 5) order = ORDER_W'(MAX_ORDER);
    else order = ORDER_W'($urandom_range(1, MAX_ORDER));
    taps = (order == 0) ? 1 : (order > MAX_ORDER) ? MAX_ORDER : order;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       gain = '0;
      1:       gain = iirdf2_pkg::GAIN_RESET;
      2:       gain = '1;
      3:       gain = GAIN_W'($urandom);
      default: gain = GAIN_W'($urandom_range(1 << 22, 1 << 24));
    endcase
    // upper write-data bits carry garbage; only the low five set the order
    junk = 20'($urandom);
    write_reg(iirdf2_pkg::REG_FILTER_ORDER, {junk, order});
    write_reg(iirdf2_pkg::REG_INVERSE_GAIN, gain);
    if ($urandom_range(0, 7) == 0)
      write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B, GAIN_W'($urandom));

    // tame sets keep the feedback sum at most one half so the state stays in range
    tame = ($urandom_range(0, 3) != 0);
    for (k = 0; k < taps; k++)
      send_word(iirdf2_pkg::MODE_LOAD_FB, IDX_W'(k),
                rand_coef(tame ? (1 << 19) / taps : 0), rand_sample());
    for (k = 0; k <= taps; k++)
      send_word(iirdf2_pkg::MODE_LOAD_FF, IDX_W'(k),
                rand_coef(tame ? (1 << 20) : 0), rand_sample());
    if ($urandom_range(0, 1) == 0)
      send_word(iirdf2_pkg::MODE_CLEAR, IDX_W'($urandom), rand_coef(0), rand_sample());

    run_len = $urandom_range(16, 64);
    for (k = 0; k < run_len; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 86)
        send_word(iirdf2_pkg::MODE_FILTER, IDX_W'($urandom), rand_coef(0), rand_sample());
      else if (pick < 94)
        send_word($urandom_range(0, 1) ? iirdf2_pkg::MODE_LOAD_FB : iirdf2_pkg::MODE_LOAD_FF,
                  IDX_W'($urandom), rand_coef(tame ? (1 << 19) : 0), rand_sample());
      else if (pick < 98)
        send_word(iirdf2_pkg::MODE_CLEAR, IDX_W'($urandom), rand_coef(0), rand_sample());
      else
        settle();
    end
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned directed_words;
    int unsigned waited;
    bit          leftover;
    leftover = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    directed_words = effective_words;

    // idle phases: none, source gaps, sink stalls, both light
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 79; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 79; end
        default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
      endcase
      while (effective_words < directed_words + (phase + 1) * (RANDOM_WORDS / 4))
        run_episode();
    end

    // drain: wait for every expected result, then let the pipeline go quiet
    s_tvalid <= 1'b0;
    @(posedge clk);
    for (waited = 0; samples_due != 0 && waited < DRAIN_LIMIT; waited++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (samples_due != 0) begin
      $error("%0d expected result words never arrived", samples_due);
      leftover = 1'b1;
    end

    $display("Run covered %0d input words: %0d filter, %0d coefficient loads, %0d clears",
             words_sent, filter_words, load_words, clear_words);
    $display("%0d register writes; compared %0d result words, %0d of them saturated",
             cfg_writes, samples_checked, samples_clipped);
    if (mismatch_count == 0 && !leftover)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
